[rtl/core/hbrp_pkg.sv]
// hbrp_pkg: shared types, parse phase codes and status codes for the
// http byte range parser. No dependencies.

package hbrp_pkg;

   // largest legal byte position
   localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

   // parse phases
   localparam logic [3:0] PH_LWS    = 4'd0;
   localparam logic [3:0] PH_UNIT   = 4'd1;
   localparam logic [3:0] PH_WS1    = 4'd2;
   localparam logic [3:0] PH_WS2    = 4'd3;
   localparam logic [3:0] PH_SDIG0  = 4'd4;
   localparam logic [3:0] PH_SDIGS  = 4'd5;
   localparam logic [3:0] PH_EFIRST = 4'd6;
   localparam logic [3:0] PH_EWS    = 4'd7;
   localparam logic [3:0] PH_EDIG0  = 4'd8;
   localparam logic [3:0] PH_EDIGS  = 4'd9;
   localparam logic [3:0] PH_DONE   = 4'd10;

   // result status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_UNIT   = 3'd1;
   localparam logic [2:0] ST_NO_EQUALS  = 3'd2;
   localparam logic [2:0] ST_BAD_START  = 3'd3;
   localparam logic [2:0] ST_NO_HYPHEN  = 3'd4;
   localparam logic [2:0] ST_BAD_END    = 3'd5;
   localparam logic [2:0] ST_START_GT   = 3'd6;
   localparam logic [2:0] ST_EXTRA      = 3'd7;

   // last index of the unit text
   localparam logic [2:0] UNIT_LAST = 3'd4;

   typedef struct packed {
      logic [7:0] ch;
      logic       terminator;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [30:0] range_start;
      logic [30:0] range_end;
      logic        has_end;
   } rsp_word_type;

   // characters of the unit "bytes"
   function automatic logic [7:0] unit_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h62;
         3'd1:    c = 8'h79;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h65;
         3'd4:    c = 8'h73;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

[rtl/core/hbrp_core.sv]
// hbrp_core: parse state and one-character step of the range parser.
// Depends on hbrp_pkg.

module hbrp_core
   import hbrp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_word_type step_word,
   output rsp_word_type result
);

   logic [3:0]  phase_ff, phase_in;
   logic [2:0]  idx_ff, idx_in;
   logic [30:0] acc_ff, acc_in;
   logic        ovf_ff, ovf_in;
   logic        neg_ff, neg_in;
   logic [30:0] start_ff, start_in;
   logic [30:0] end_ff, end_in;
   logic        endp_ff, endp_in;
   logic [2:0]  err_ff, err_in;

   logic [7:0]  ch;
   logic        is_sp, is_dg, bad;
   logic [3:0]  eff_ph;
   logic [2:0]  eff_idx;
   logic [30:0] eff_acc, eff_start;
   logic        eff_ovf, eff_neg;
   logic [34:0] prod;
   logic        prod_ovf;

   assign ch    = step_word.ch;
   assign is_sp = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
   assign is_dg = (ch >= 8'h30) && (ch <= 8'h39);

   // resolve the phases that hand the same character on to another phase
   always_comb begin
      eff_ph    = phase_ff;
      eff_idx   = idx_ff;
      eff_acc   = acc_ff;
      eff_ovf   = ovf_ff;
      eff_neg   = neg_ff;
      eff_start = start_ff;
      if (phase_ff == PH_LWS && !is_sp) begin
         eff_ph  = PH_UNIT;
         eff_idx = 3'd0;
      end
      // a lone minus on the start doubles as the hyphen
      if ((phase_ff == PH_SDIG0 && !is_dg && neg_ff) || phase_ff == PH_EFIRST) begin
         eff_ph    = PH_EWS;
         eff_start = (phase_ff == PH_SDIG0) ? 31'd0 : start_ff;
         eff_acc   = 31'd0;
         eff_ovf   = 1'b0;
         eff_neg   = 1'b0;
      end
      if (phase_ff == PH_WS2 && !is_sp) begin
         eff_acc = 31'd0;
         eff_ovf = 1'b0;
         eff_neg = 1'b0;
      end
   end

   // times ten plus digit
   assign prod     = {1'b0, eff_acc, 3'b000} + {3'b000, eff_acc, 1'b0} + {31'd0, ch[3:0]};
   assign prod_ovf = prod > {4'd0, VALUE_MAX};
   assign bad      = eff_ovf || (eff_neg && eff_acc != 31'd0);

   // next state and result
   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      neg_in   = neg_ff;
      start_in = start_ff;
      end_in   = end_ff;
      endp_in  = endp_ff;
      err_in   = err_ff;
      result   = '0;
      if (step_en) begin
         if (phase_ff != PH_DONE) begin
            if (step_word.terminator || ch == 8'd0) begin
               // end of string: settle the status from the phase reached
               phase_in = PH_DONE;
               case (phase_ff)
                  PH_LWS, PH_UNIT: err_in = ST_BAD_UNIT;
                  PH_WS1:          err_in = ST_NO_EQUALS;
                  PH_WS2:          err_in = ST_NO_HYPHEN;
                  PH_SDIG0:        err_in = neg_ff ? ST_OK : ST_NO_HYPHEN;
                  PH_SDIGS: begin
                     if (ovf_ff || (neg_ff && acc_ff != 31'd0)) begin
                        err_in = ST_BAD_START;
                     end else begin
                        start_in = acc_ff;
                        err_in   = ST_NO_HYPHEN;
                     end
                  end
                  PH_EFIRST:       err_in = ST_OK;
                  PH_EWS, PH_EDIG0: begin
                     end_in  = 31'd0;
                     endp_in = 1'b1;
                     err_in  = (start_ff != 31'd0) ? ST_START_GT : ST_EXTRA;
                  end
                  PH_EDIGS: begin
                     if (ovf_ff || (neg_ff && acc_ff != 31'd0)) begin
                        err_in = ST_BAD_END;
                     end else begin
                        end_in  = acc_ff;
                        endp_in = 1'b1;
                        err_in  = (start_ff > acc_ff) ? ST_START_GT : ST_OK;
                     end
                  end
                  default: err_in = err_ff;
               endcase
            end else begin
               // take one character
               phase_in = eff_ph;
               idx_in   = eff_idx;
               acc_in   = eff_acc;
               ovf_in   = eff_ovf;
               neg_in   = eff_neg;
               start_in = eff_start;
               if (is_dg && !eff_ovf) begin
                  if (prod_ovf) begin
                     ovf_in = 1'b1;
                  end else begin
                     acc_in = prod[30:0];
                  end
               end
               case (eff_ph)
                  PH_LWS: begin
                     phase_in = PH_LWS;
                  end
                  PH_UNIT: begin
                     if (ch == unit_char(eff_idx)) begin
                        idx_in = eff_idx + 3'd1;
                        if (eff_idx == UNIT_LAST) begin
                           phase_in = PH_WS1;
                        end
                     end else begin
                        err_in   = ST_BAD_UNIT;
                        phase_in = PH_DONE;
                     end
                  end
                  PH_WS1: begin
                     if (ch == 8'h3D) begin
                        phase_in = PH_WS2;
                     end else if (!is_sp) begin
                        err_in   = ST_NO_EQUALS;
                        phase_in = PH_DONE;
                     end
                  end
                  PH_WS2: begin
                     if (is_sp) begin
                        phase_in = PH_WS2;
                     end else if (ch == 8'h2B) begin
                        phase_in = PH_SDIG0;
                     end else if (ch == 8'h2D) begin
                        neg_in   = 1'b1;
                        phase_in = PH_SDIG0;
                     end else if (is_dg) begin
                        phase_in = PH_SDIGS;
                     end else begin
                        err_in   = ST_NO_HYPHEN;
                        phase_in = PH_DONE;
                     end
                  end
                  PH_SDIG0: begin
                     if (is_dg) begin
                        phase_in = PH_SDIGS;
                     end else begin
                        err_in   = ST_NO_HYPHEN;
                        phase_in = PH_DONE;
                     end
                  end
                  PH_SDIGS: begin
                     if (!is_dg) begin
                        if (bad) begin
                           err_in   = ST_BAD_START;
                           phase_in = PH_DONE;
                        end else begin
                           start_in = eff_acc;
                           if (ch == 8'h2D) begin
                              phase_in = PH_EFIRST;
                           end else begin
                              err_in   = ST_NO_HYPHEN;
                              phase_in = PH_DONE;
                           end
                        end
                     end
                  end
                  PH_EWS: begin
                     if (is_sp) begin
                        phase_in = PH_EWS;
                     end else if (ch == 8'h2B) begin
                        phase_in = PH_EDIG0;
                     end else if (ch == 8'h2D) begin
                        neg_in   = 1'b1;
                        phase_in = PH_EDIG0;
                     end else if (is_dg) begin
                        phase_in = PH_EDIGS;
                     end else begin
                        end_in   = 31'd0;
                        endp_in  = 1'b1;
                        err_in   = (eff_start != 31'd0) ? ST_START_GT : ST_EXTRA;
                        phase_in = PH_DONE;
                     end
                  end
                  PH_EDIG0: begin
                     if (is_dg) begin
                        phase_in = PH_EDIGS;
                     end else begin
                        end_in   = 31'd0;
                        endp_in  = 1'b1;
                        err_in   = (eff_start != 31'd0) ? ST_START_GT : ST_EXTRA;
                        phase_in = PH_DONE;
                     end
                  end
                  PH_EDIGS: begin
                     if (!is_dg) begin
                        phase_in = PH_DONE;
                        if (bad) begin
                           err_in = ST_BAD_END;
                        end else begin
                           end_in  = eff_acc;
                           endp_in = 1'b1;
                           err_in  = (eff_start > eff_acc) ? ST_START_GT : ST_EXTRA;
                        end
                     end
                  end
                  default: phase_in = PH_DONE;
               endcase
            end
         end
         // terminator: emit the result and start a new header
         if (step_word.terminator) begin
            result.status      = err_in;
            result.range_start = start_in;
            result.range_end   = endp_in ? end_in : 31'd0;
            result.has_end     = endp_in;
            phase_in = PH_LWS;
            idx_in   = 3'd0;
            acc_in   = 31'd0;
            ovf_in   = 1'b0;
            neg_in   = 1'b0;
            start_in = 31'd0;
            end_in   = 31'd0;
            endp_in  = 1'b0;
            err_in   = ST_OK;
         end
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LWS;
         idx_ff   <= 3'd0;
         acc_ff   <= 31'd0;
         ovf_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         start_ff <= 31'd0;
         end_ff   <= 31'd0;
         endp_ff  <= 1'b0;
         err_ff   <= ST_OK;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         neg_ff   <= neg_in;
         start_ff <= start_in;
         end_ff   <= end_in;
         endp_ff  <= endp_in;
         err_ff   <= err_in;
      end
   end

   // a terminator always returns the parser to the header start
   a_term_restart: assert property (@(posedge clock) disable iff (reset)
      step_en && step_word.terminator |=> phase_ff == PH_LWS && err_ff == ST_OK)
      else $error("parser did not restart after terminator");

   // an error code only stands once parsing is done
   a_err_done: assert property (@(posedge clock) disable iff (reset)
      err_ff != ST_OK |-> phase_ff == PH_DONE)
      else $error("error latched while still parsing");

   // the accumulator never exceeds the legal range and the phase is a legal code
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      acc_ff <= VALUE_MAX && (phase_ff <= PH_DONE))
      else $error("parser state out of range");

endmodule

[rtl/core/http_byte_range_parser.sv]
// http_byte_range_parser: top level; input register, parse core and result
// register with valid/stall handshakes. Depends on hbrp_pkg and hbrp_core.

// One header character is taken per word and the parser sustains one word
// per cycle while req_stall is low. A word is captured in the input
// register, the parse step (state update and the times-ten accumulate) runs
// from there, and the word carrying terminator loads the result register,
// from which its result is offered. Character words keep flowing while a
// result waits on rsp_stall; only a terminator word stalls behind an
// untaken result. Status codes: 0 ok, 1 unit not bytes, 2 no '=', 3 bad
// start, 4 no hyphen, 5 bad end, 6 start greater than end, 7 extra parts.

module http_byte_range_parser
   import hbrp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;
   logic         out_free, step_en, load_out;
   rsp_word_type result;

   // step unless a terminator would overwrite a waiting result
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && (!in_word_ff.terminator || out_free);
   assign load_out  = step_en && in_word_ff.terminator;
   assign req_stall = in_valid_ff && !step_en;

   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !step_en);
   assign out_valid_in = load_out || (out_valid_ff && rsp_stall);

   hbrp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .step_word (in_word_ff),
      .result    (result)
   );

   // handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
      if (load_out) begin
         out_word_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   // stall only comes from a held input word
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_word_ff.terminator && out_valid_ff)
      else $error("input stalled without a blocked terminator");

   // no end value without has_end
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.has_end |-> rsp_word.range_end == 31'd0)
      else $error("range_end set without has_end");

   // an ok result with an end is ordered
   a_ok_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_OK && rsp_word.has_end
         |-> rsp_word.range_start <= rsp_word.range_end)
      else $error("ok result with start above end");

   // start above end always reports an end value
   a_gt_has_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_START_GT |-> rsp_word.has_end)
      else $error("start above end without end value");

endmodule
